>>> rtl/core/ile_pkg.sv
package ile_pkg;

	localparam int KIND_W   = 4;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 7;
	localparam int STATUS_W = 3;
	localparam int CMP_W    = 8;

	localparam logic [KIND_W-1:0] K_PUSH_FRONT = 4'd0;
	localparam logic [KIND_W-1:0] K_PUSH_BACK  = 4'd1;
	localparam logic [KIND_W-1:0] K_POP_FRONT  = 4'd2;
	localparam logic [KIND_W-1:0] K_POP_BACK   = 4'd3;
	localparam logic [KIND_W-1:0] K_INSERT     = 4'd4;
	localparam logic [KIND_W-1:0] K_DELETE     = 4'd5;
	localparam logic [KIND_W-1:0] K_NEXT       = 4'd6;
	localparam logic [KIND_W-1:0] K_PREV       = 4'd7;
	localparam logic [KIND_W-1:0] K_CLEAR      = 4'd8;
	localparam logic [KIND_W-1:0] K_DUMP_FWD   = 4'd9;
	localparam logic [KIND_W-1:0] K_DUMP_REV   = 4'd10;

	localparam logic [STATUS_W-1:0] S_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] S_EMPTY   = 3'd1;
	localparam logic [STATUS_W-1:0] S_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] S_MISSING = 3'd3;
	localparam logic [STATUS_W-1:0] S_NONEIGH = 3'd4;

	typedef struct packed {
		logic exec;
		logic dump_step;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic dump_go;
		logic dump_last;
	} sts_t;

endpackage

>>> rtl/core/ile_ctrl.sv
module ile_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  ile_pkg::sts_t sts,
	output ile_pkg::cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DUMP = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	assign s_tready      = (state_q == ST_IDLE) && sts.out_free;
	assign accept        = s_tvalid && s_tready;
	assign cmd.exec      = accept;
	assign cmd.dump_step = (state_q == ST_DUMP) && sts.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && sts.dump_go) begin
					state_d = ST_DUMP;
				end
			end
			ST_DUMP: begin
				if (cmd.dump_step && sts.dump_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/ile_dp.sv
module ile_dp #(
	parameter int CAPACITY = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ile_pkg::cmd_t                         cmd,
	output ile_pkg::sts_t                         sts,
	input  logic [ile_pkg::KIND_W-1:0]            kind,
	input  logic signed [ile_pkg::VALUE_W-1:0]    value,
	input  logic [ile_pkg::POS_W-1:0]             position,
	input  logic                                  m_tready,
	output logic                                  m_tvalid,
	output logic [ile_pkg::STATUS_W-1:0]          m_status,
	output logic signed [ile_pkg::VALUE_W-1:0]    m_data,
	output logic                                  m_last
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int PW = ile_pkg::CMP_W;

	logic signed [ile_pkg::VALUE_W-1:0] cell_q [CAPACITY];
	logic [CW-1:0]                      count_q;
	logic [IW-1:0]                      dump_idx_q;
	logic [CW-1:0]                      dump_left_q;
	logic                               dump_rev_q;

	logic                               out_valid_q;
	logic [ile_pkg::STATUS_W-1:0]       out_status_q;
	logic signed [ile_pkg::VALUE_W-1:0] out_data_q;
	logic                               out_last_q;

	logic [PW-1:0]                      p8;
	logic [PW-1:0]                      n8;
	logic [PW-1:0]                      rd8;
	logic [PW-1:0]                      shift_p;
	logic [IW-1:0]                      rd_idx;
	logic signed [ile_pkg::VALUE_W-1:0] rd_data;
	logic                               full;
	logic                               empty;
	logic                               is_dump;
	logic                               ins_en;
	logic                               del_en;
	logic                               clr_en;
	logic                               res_valid;
	logic [ile_pkg::STATUS_W-1:0]       res_status;
	logic signed [ile_pkg::VALUE_W-1:0] res_data;

	assign p8      = {1'b0, position};
	assign n8      = PW'(count_q);
	assign full    = (count_q == CW'(CAPACITY));
	assign empty   = (count_q == '0);
	assign is_dump = (kind == ile_pkg::K_DUMP_FWD) || (kind == ile_pkg::K_DUMP_REV);
	assign rd8     = (kind == ile_pkg::K_PREV) ? (p8 - PW'(1)) : (p8 + PW'(1));
	assign rd_idx  = cmd.dump_step ? dump_idx_q : rd8[IW-1:0];
	assign rd_data = cell_q[rd_idx];

	assign sts.out_free  = !out_valid_q || m_tready;
	assign sts.dump_go   = is_dump && !empty;
	assign sts.dump_last = (dump_left_q == CW'(1));

	always_comb begin
		ins_en     = 1'b0;
		del_en     = 1'b0;
		clr_en     = 1'b0;
		shift_p    = '0;
		res_valid  = 1'b1;
		res_status = ile_pkg::S_OK;
		res_data   = '0;
		case (kind)
			ile_pkg::K_PUSH_FRONT: begin
				if (full) begin
					res_status = ile_pkg::S_FULL;
				end else begin
					ins_en = 1'b1;
				end
			end
			ile_pkg::K_PUSH_BACK: begin
				if (full) begin
					res_status = ile_pkg::S_FULL;
				end else begin
					ins_en  = 1'b1;
					shift_p = n8;
				end
			end
			ile_pkg::K_POP_FRONT: begin
				if (empty) begin
					res_status = ile_pkg::S_EMPTY;
				end else begin
					del_en = 1'b1;
				end
			end
			ile_pkg::K_POP_BACK: begin
				if (empty) begin
					res_status = ile_pkg::S_EMPTY;
				end else begin
					del_en  = 1'b1;
					shift_p = n8 - PW'(1);
				end
			end
			ile_pkg::K_INSERT: begin
				if (full) begin
					res_status = ile_pkg::S_FULL;
				end else if (p8 > n8 + PW'(1)) begin
					res_status = ile_pkg::S_MISSING;
				end else begin
					ins_en  = 1'b1;
					shift_p = (p8 > n8) ? n8 : p8;
				end
			end
			ile_pkg::K_DELETE: begin
				if (empty) begin
					res_status = ile_pkg::S_EMPTY;
				end else if (p8 >= n8) begin
					res_status = ile_pkg::S_MISSING;
				end else begin
					del_en  = 1'b1;
					shift_p = p8;
				end
			end
			ile_pkg::K_NEXT: begin
				if (p8 > n8) begin
					res_status = ile_pkg::S_MISSING;
				end else if (p8 + PW'(1) < n8) begin
					res_data = rd_data;
				end else begin
					res_status = ile_pkg::S_NONEIGH;
				end
			end
			ile_pkg::K_PREV: begin
				if (p8 > n8) begin
					res_status = ile_pkg::S_MISSING;
				end else if ((p8 != '0) && (p8 < n8)) begin
					res_data = rd_data;
				end else begin
					res_status = ile_pkg::S_NONEIGH;
				end
			end
			ile_pkg::K_CLEAR: begin
				clr_en = 1'b1;
			end
			ile_pkg::K_DUMP_FWD, ile_pkg::K_DUMP_REV: begin
				if (empty) begin
					res_status = ile_pkg::S_EMPTY;
				end else begin
					res_valid = 1'b0;
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// shift the cell chain open or closed around the position
	always_ff @(posedge clk) begin
		if (cmd.exec && ins_en) begin
			for (int i = 1; i < CAPACITY; i++) begin
				if (PW'(i) > shift_p) begin
					cell_q[i] <= cell_q[i-1];
				end
			end
			for (int i = 0; i < CAPACITY; i++) begin
				if (PW'(i) == shift_p) begin
					cell_q[i] <= value;
				end
			end
		end
		if (cmd.exec && del_en) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				if (PW'(i) >= shift_p) begin
					cell_q[i] <= cell_q[i+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			if (ins_en) begin
				count_q <= count_q + CW'(1);
			end else if (del_en) begin
				count_q <= count_q - CW'(1);
			end else if (clr_en) begin
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dump_idx_q  <= '0;
			dump_left_q <= '0;
			dump_rev_q  <= 1'b0;
		end else if (cmd.exec && sts.dump_go) begin
			dump_rev_q  <= (kind == ile_pkg::K_DUMP_REV);
			dump_idx_q  <= (kind == ile_pkg::K_DUMP_REV) ? IW'(count_q - CW'(1)) : '0;
			dump_left_q <= count_q;
		end else if (cmd.dump_step) begin
			dump_idx_q  <= dump_rev_q ? (dump_idx_q - IW'(1)) : (dump_idx_q + IW'(1));
			dump_left_q <= dump_left_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.exec && res_valid) || cmd.dump_step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dump_step) begin
			out_status_q <= ile_pkg::S_OK;
			out_data_q   <= rd_data;
			out_last_q   <= sts.dump_last;
		end else if (cmd.exec && res_valid) begin
			out_status_q <= res_status;
			out_data_q   <= res_data;
			out_last_q   <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_status = out_status_q;
	assign m_data   = out_data_q;
	assign m_last   = out_last_q;

endmodule

>>> rtl/core/indexed_list_engine.sv
// channel  dir  tdata                         tuser          tlast
// s_*      in   [31:0] value, [38:32] position [3:0] kind     -
// m_*      out  [31:0] data                    [2:0] status   last of the item
//
// One item per cycle for every operation while s_tready is high; insert and delete shift the cell chain at once.
// A dump of n elements holds s_tready low until its last beat is loaded into the output register, one beat per element.
// A full output register with m_tready low stalls both sides until the beat is taken.
// arst_n clears the element count, the controller and the output valid; cells hold no reset.
module indexed_list_engine #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // value[31:0], position[38:32], zero[39]
	input  logic [3:0]  s_tuser,   // kind[3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // data[31:0]
	output logic [2:0]  m_tuser,   // status[2:0]
	output logic        m_tlast
);

	ile_pkg::cmd_t cmd;
	ile_pkg::sts_t sts;

	logic signed [ile_pkg::VALUE_W-1:0] data;

	ile_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ile_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.kind     (s_tuser),
		.value    (s_tdata[31:0]),
		.position (s_tdata[38:32]),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_status (m_tuser),
		.m_data   (data),
		.m_last   (m_tlast)
	);

	assign m_tdata = data;

endmodule

>>> tb/indexed_list_engine_test.sv
module indexed_list_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH    = 16;
	localparam int PHASE_OPS     = 85;
	localparam int SETTLE_CYCLES = 20;
	localparam int DIRECTED_ROWS = 28;

	localparam logic [ile_pkg::KIND_W-1:0] K_UNUSED_LO = 4'd11;
	localparam logic [ile_pkg::KIND_W-1:0] K_UNUSED_HI = 4'd15;

	localparam logic [ile_pkg::VALUE_W-1:0] EDGE_VALUES [4] = '{
		32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF
	};

	typedef struct packed {
		logic [ile_pkg::STATUS_W-1:0] status;
		logic [ile_pkg::VALUE_W-1:0]  data;
		logic                         last;
	} list_beat_t;

	typedef struct packed {
		logic [ile_pkg::KIND_W-1:0]   kind;
		logic [ile_pkg::VALUE_W-1:0]  value;
		logic [ile_pkg::POS_W-1:0]    pos;
		logic [4:0]                   reps;
		logic                         typed;
		logic [ile_pkg::STATUS_W-1:0] status;
	} list_cmd_t;

	// reps of zero issues the row once; typed rows carry their own status
	localparam list_cmd_t DIRECTED_CMDS [DIRECTED_ROWS] = '{
		'{ile_pkg::K_POP_FRONT,  32'h0,         7'd0,   5'd0,  1'b1, ile_pkg::S_EMPTY},
		'{ile_pkg::K_POP_BACK,   32'h0,         7'd0,   5'd0,  1'b1, ile_pkg::S_EMPTY},
		'{ile_pkg::K_DELETE,     32'h0,         7'd0,   5'd0,  1'b1, ile_pkg::S_EMPTY},
		'{ile_pkg::K_DUMP_FWD,   32'h0,         7'd0,   5'd0,  1'b1, ile_pkg::S_EMPTY},
		'{ile_pkg::K_NEXT,       32'h0,         7'd0,   5'd0,  1'b1, ile_pkg::S_NONEIGH},
		'{ile_pkg::K_PREV,       32'h0,         7'd1,   5'd0,  1'b1, ile_pkg::S_MISSING},
		'{ile_pkg::K_INSERT,     32'h1,         7'd2,   5'd0,  1'b1, ile_pkg::S_MISSING},
		'{ile_pkg::K_PUSH_BACK,  32'h7FFF_FFFF, 7'd0,   5'd0,  1'b1, ile_pkg::S_OK},
		'{ile_pkg::K_PUSH_FRONT, 32'h8000_0000, 7'd127, 5'd0,  1'b1, ile_pkg::S_OK},
		'{ile_pkg::K_INSERT,     32'hFFFF_FFFF, 7'd2,   5'd0,  1'b1, ile_pkg::S_OK},
		'{ile_pkg::K_INSERT,     32'h0,         7'd1,   5'd0,  1'b0, ile_pkg::S_OK},
		'{ile_pkg::K_NEXT,       32'h0,         7'd0,   5'd0,  1'b0, ile_pkg::S_OK},
		'{ile_pkg::K_PREV,       32'h0,         7'd3,   5'd0,  1'b0, ile_pkg::S_OK},
		'{ile_pkg::K_NEXT,       32'h0,         7'd4,   5'd0,  1'b1, ile_pkg::S_NONEIGH},
		'{ile_pkg::K_PREV,       32'h0,         7'd0,   5'd0,  1'b1, ile_pkg::S_NONEIGH},
		'{ile_pkg::K_DELETE,     32'h0,         7'd4,   5'd0,  1'b1, ile_pkg::S_MISSING},
		'{ile_pkg::K_DELETE,     32'h0,         7'd1,   5'd0,  1'b0, ile_pkg::S_OK},
		'{ile_pkg::K_DUMP_FWD,   32'h0,         7'd0,   5'd0,  1'b0, ile_pkg::S_OK},
		'{ile_pkg::K_DUMP_REV,   32'h0,         7'd0,   5'd0,  1'b0, ile_pkg::S_OK},
		'{K_UNUSED_LO,           32'h0,         7'd0,   5'd0,  1'b0, ile_pkg::S_OK},
		'{K_UNUSED_HI,           32'hFFFF_FFFF, 7'd127, 5'd0,  1'b0, ile_pkg::S_OK},
		'{ile_pkg::K_INSERT,     32'h55AA_33CC, 7'd127, 5'd0,  1'b1, ile_pkg::S_MISSING},
		'{ile_pkg::K_PUSH_BACK,  32'h1234_5678, 7'd0,   5'd12, 1'b0, ile_pkg::S_OK},
		'{ile_pkg::K_PUSH_FRONT, 32'h0BAD_F00D, 7'd0,   5'd0,  1'b1, ile_pkg::S_FULL},
		'{ile_pkg::K_INSERT,     32'h0BAD_F00D, 7'd127, 5'd0,  1'b1, ile_pkg::S_FULL},
		'{ile_pkg::K_DUMP_REV,   32'h0,         7'd0,   5'd0,  1'b0, ile_pkg::S_OK},
		'{ile_pkg::K_CLEAR,      32'h0,         7'd0,   5'd0,  1'b1, ile_pkg::S_OK},
		'{ile_pkg::K_POP_BACK,   32'h0,         7'd0,   5'd0,  1'b1, ile_pkg::S_EMPTY}
	};

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;   // value[31:0], position[38:32], zero[39]
	logic [3:0]  s_tuser  = '0;   // kind[3:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // data[31:0]
	logic [2:0]  m_tuser;         // status[2:0]
	logic        m_tlast;

	logic [ile_pkg::VALUE_W-1:0] list_image [$];
	list_beat_t                  beats_due [$];
	int                          mismatch_count = 0;
	int                          src_idle_pct   = 0;
	int                          sink_idle_pct  = 0;

	indexed_list_engine #(
		.CAPACITY(LIST_DEPTH)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[indexed_list_engine] ERROR");
		$finish;
	end

	function automatic void predict_list_op(input logic [ile_pkg::KIND_W-1:0] kind,
		input logic [ile_pkg::VALUE_W-1:0] value, input logic [ile_pkg::POS_W-1:0] pos);
		int                           n;
		int                           p;
		logic [ile_pkg::STATUS_W-1:0] st;
		logic [ile_pkg::VALUE_W-1:0]  data;
		n    = list_image.size();
		p    = pos;
		st   = ile_pkg::S_OK;
		data = '0;
		case (kind)
			ile_pkg::K_PUSH_FRONT: begin
				if (n >= LIST_DEPTH) st = ile_pkg::S_FULL;
				else list_image.push_front(value);
			end
			ile_pkg::K_PUSH_BACK: begin
				if (n >= LIST_DEPTH) st = ile_pkg::S_FULL;
				else list_image.push_back(value);
			end
			ile_pkg::K_POP_FRONT: begin
				if (n == 0) st = ile_pkg::S_EMPTY;
				else void'(list_image.pop_front());
			end
			ile_pkg::K_POP_BACK: begin
				if (n == 0) st = ile_pkg::S_EMPTY;
				else void'(list_image.pop_back());
			end
			ile_pkg::K_INSERT: begin
				if (n >= LIST_DEPTH) st = ile_pkg::S_FULL;
				else if (p > n + 1) st = ile_pkg::S_MISSING;
				else if (p >= n) list_image.push_back(value);
				else list_image.insert(p, value);
			end
			ile_pkg::K_DELETE: begin
				if (n == 0) st = ile_pkg::S_EMPTY;
				else if (p >= n) st = ile_pkg::S_MISSING;
				else list_image.delete(p);
			end
			ile_pkg::K_NEXT: begin
				if (p > n) st = ile_pkg::S_MISSING;
				else if (p + 1 < n) data = list_image[p + 1];
				else st = ile_pkg::S_NONEIGH;
			end
			ile_pkg::K_PREV: begin
				if (p > n) st = ile_pkg::S_MISSING;
				else if (p >= 1 && p < n) data = list_image[p - 1];
				else st = ile_pkg::S_NONEIGH;
			end
			ile_pkg::K_CLEAR: begin
				list_image.delete();
			end
			ile_pkg::K_DUMP_FWD, ile_pkg::K_DUMP_REV: begin
				if (n == 0) begin
					st = ile_pkg::S_EMPTY;
				end else begin
					for (int i = 0; i < n; i++)
						beats_due.push_back('{ile_pkg::S_OK,
							list_image[(kind == ile_pkg::K_DUMP_FWD) ? i : n - 1 - i],
							i + 1 == n});
					return;
				end
			end
			default: return;
		endcase
		beats_due.push_back('{st, data, 1'b1});
	endfunction

	task automatic issue_list_op(input logic [ile_pkg::KIND_W-1:0] kind,
		input logic [ile_pkg::VALUE_W-1:0] value, input logic [ile_pkg::POS_W-1:0] pos,
		input logic typed, input logic [ile_pkg::STATUS_W-1:0] typed_status);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {1'b0, pos, value};
		do @(posedge clk); while (!s_tready);
		predict_list_op(kind, value, pos);
		if (typed)
			beats_due[beats_due.size() - 1] = '{typed_status, '0, 1'b1};
	endtask

	task automatic drain_list;
		s_tvalid <= 1'b0;
		while (beats_due.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin : check_beats
		list_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (beats_due.size() == 0) begin
				$display("%0t: unexpected beat status %0d data %h last %b",
					$time, m_tuser, m_tdata, m_tlast);
				mismatch_count++;
			end else begin
				want = beats_due.pop_front();
				if (m_tuser !== want.status || m_tdata !== want.data || m_tlast !== want.last) begin
					$display("%0t: expected status %0d data %h last %b,",
						$time, want.status, want.data, want.last,
						" got status %0d data %h last %b", m_tuser, m_tdata, m_tlast);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : stimulus
		list_cmd_t                   cmd;
		logic [ile_pkg::KIND_W-1:0]  kind;
		logic [ile_pkg::VALUE_W-1:0] value;
		logic [ile_pkg::POS_W-1:0]   pos;
		logic                        grow;
		int                          n;
		int                          r;
		int                          pick;
		int                          draw;
		int                          issued;
		grow = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct  = 35;
		sink_idle_pct = 50;
		for (int row = 0; row < DIRECTED_ROWS; row++) begin
			cmd = DIRECTED_CMDS[row];
			for (int k = 0; k <= cmd.reps; k++)
				issue_list_op(cmd.kind, cmd.value + k[ile_pkg::VALUE_W-1:0], cmd.pos,
					cmd.typed, cmd.status);
		end
		drain_list();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct  = 35;
					sink_idle_pct = 50;
				end
				1: begin
					src_idle_pct  = 50;
					sink_idle_pct = 35;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			issued = 0;
			while (issued < PHASE_OPS) begin
				n = list_image.size();
				if (n >= LIST_DEPTH) grow = 1'b0;
				else if (n == 0) grow = 1'b1;
				r    = $urandom_range(99);
				pick = $urandom_range(3);
				if (r < 3) begin
					draw = $urandom_range(K_UNUSED_HI, K_UNUSED_LO);
					kind = draw[ile_pkg::KIND_W-1:0];
				end
				else if (r < 10) kind = r[0] ? ile_pkg::K_DUMP_FWD : ile_pkg::K_DUMP_REV;
				else if (r < 12) kind = ile_pkg::K_CLEAR;
				else if (r < 24) kind = r[0] ? ile_pkg::K_NEXT : ile_pkg::K_PREV;
				else if ((r < 80) ? grow : ($urandom_range(1) == 1))
					kind = (pick == 0) ? ile_pkg::K_PUSH_FRONT
						: (pick == 1) ? ile_pkg::K_PUSH_BACK : ile_pkg::K_INSERT;
				else
					kind = (pick == 0) ? ile_pkg::K_POP_FRONT
						: (pick == 1) ? ile_pkg::K_POP_BACK : ile_pkg::K_DELETE;
				value = ($urandom_range(9) == 0) ? EDGE_VALUES[$urandom_range(3)] : $urandom;
				draw  = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(n + 1);
				pos   = draw[ile_pkg::POS_W-1:0];
				issue_list_op(kind, value, pos, 1'b0, ile_pkg::S_OK);
				if (kind <= ile_pkg::K_DUMP_REV) issued++;
			end
			drain_list();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("[indexed_list_engine] OK");
		else
			$display("[indexed_list_engine] ERROR");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/ile_pkg.sv
rtl/core/ile_ctrl.sv
rtl/core/ile_dp.sv
rtl/core/indexed_list_engine.sv
tb/indexed_list_engine_test.sv
